FILE: src/qrs_pkg.sv
`timescale 1ns / 1ps
// Package for the quadratic root solver: field widths, status codes and the
// transaction payload types. No dependencies.
package qrs_pkg;

  // Width of every coefficient and root field on the channels
  localparam int FIELD_BITS = 32;
  // Width and reset value of the zero tolerance register
  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

  // Root classification reported with every result
  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ONE  = 2'd1,
    ST_TWO  = 2'd2,
    ST_ANY  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] coef_a;
    logic signed [FIELD_BITS-1:0] coef_b;
    logic signed [FIELD_BITS-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    status_e                      root_status;
    logic signed [FIELD_BITS-1:0] root_plus;
    logic signed [FIELD_BITS-1:0] root_minus;
    logic signed [FIELD_BITS-1:0] root_sum;
    logic                         saturated;
  } root_t;

endpackage

FILE: src/qrs_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the quadratic root solver.
// Depends on qrs_pkg for the payload types.
interface qrs_coef_if;
  logic          valid;
  logic          ready;
  qrs_pkg::coef_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qrs_root_if;
  logic          valid;
  logic          ready;
  qrs_pkg::root_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Quadratic root solver top level: a fully pipelined fixed point datapath.
// Depends on qrs_pkg and the channel interfaces in qrs_intf.sv.

// Solves a*x^2 + b*x + c = 0 for signed fixed point coefficients (Q16.16 by
// default) and returns the root classification, both roots, their sum and a
// clipping flag. The block takes one equation per clock cycle while the
// output is not stalled. Each equation passes through the bit-per-stage square
// root pipeline (WORD_BITS + 1 stages) followed by the bit-per-stage restoring
// divider (WORD_BITS + FRAC_BITS + 1 stages), plus eight stages of input,
// multiply, discriminant, classify, numerator, sign, sum and clip. The whole
// pipeline holds when the output is stalled, so no transaction is ever
// dropped. The zero tolerance register may be written only while no
// transaction is in flight.
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qrs_pkg::TOL_BITS-1:0]   cfg_wdata_i,
  qrs_coef_if.sink                       coef_if,
  qrs_root_if.source                     root_if
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int TB   = qrs_pkg::TOL_BITS;
  localparam int PW   = 2 * W;          // product width
  localparam int DW   = 2 * W + 1;      // discriminant magnitude width
  localparam int SW   = W + 1;          // square root width
  localparam int RADW = 2 * SW;         // radicand width
  localparam int RW   = SW + 2;         // square root remainder width
  localparam int NBW  = W + 2;          // signed numerator base width
  localparam int VW   = W + 1;          // divisor magnitude width
  localparam int NW   = W + 1 + F;      // dividend and quotient width
  localparam int SVW  = NW + 1;         // signed quotient width
  localparam int SUMW = NW + 2;         // root sum width
  localparam int CMPW = (DW > TB + F) ? DW : TB + F;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_LIN,
    MODE_DBL,
    MODE_TWO
  } mode_e;

  // Pipeline advance: every stage moves when the output register can move
  logic adv;
  logic out_v_q;

  assign adv = !out_v_q || root_if.ready;
  assign coef_if.ready = adv;

  // Zero tolerance register
  logic [TB-1:0] tol_q;
  logic [TB-1:0] tol_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qrs_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign tol_eff = (tol_q == '0) ? TB'(1) : tol_q;

  // Stage 0: take the coefficients, form magnitudes and zero flags
  logic signed [W-1:0] in_a, in_b, in_c;
  logic [W-1:0]        in_ma, in_mb, in_mc;

  assign in_a  = $signed(coef_if.data.coef_a[W-1:0]);
  assign in_b  = $signed(coef_if.data.coef_b[W-1:0]);
  assign in_c  = $signed(coef_if.data.coef_c[W-1:0]);
  assign in_ma = in_a[W-1] ? (~in_a + W'(1)) : in_a;
  assign in_mb = in_b[W-1] ? (~in_b + W'(1)) : in_b;
  assign in_mc = in_c[W-1] ? (~in_c + W'(1)) : in_c;

  logic                s0_v_q;
  logic signed [W-1:0] s0_a_q, s0_b_q, s0_c_q;
  logic [W-1:0]        s0_ma_q, s0_mb_q, s0_mc_q;
  logic                s0_za_q, s0_zb_q, s0_zc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= coef_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_a_q  <= in_a;
      s0_b_q  <= in_b;
      s0_c_q  <= in_c;
      s0_ma_q <= in_ma;
      s0_mb_q <= in_mb;
      s0_mc_q <= in_mc;
      s0_za_q <= in_ma < W'(tol_eff);
      s0_zb_q <= in_mb < W'(tol_eff);
      s0_zc_q <= in_mc < W'(tol_eff);
    end
  end

  // Stage 1: products |a|*|c| and b*b
  logic                s1_v_q;
  logic signed [W-1:0] s1_a_q, s1_b_q, s1_c_q;
  logic [PW-1:0]       s1_ac_q, s1_bb_q;
  logic                s1_opp_q;
  logic                s1_za_q, s1_zb_q, s1_zc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q   <= s0_a_q;
      s1_b_q   <= s0_b_q;
      s1_c_q   <= s0_c_q;
      s1_ac_q  <= s0_ma_q * s0_mc_q;
      s1_bb_q  <= s0_mb_q * s0_mb_q;
      s1_opp_q <= s0_a_q[W-1] ^ s0_c_q[W-1];
      s1_za_q  <= s0_za_q;
      s1_zb_q  <= s0_zb_q;
      s1_zc_q  <= s0_zc_q;
    end
  end

  // Stage 2: discriminant b*b - 4*a*c in sign-magnitude form
  logic [DW-1:0] d_q4, d_bb, d_mag;
  logic          d_neg;

  assign d_q4 = {s1_ac_q[PW-2:0], 2'b00};
  assign d_bb = DW'(s1_bb_q);

  always_comb begin
    priority if (s1_ac_q != '0 && s1_opp_q) begin
      d_mag = d_bb + d_q4;
      d_neg = 1'b0;
    end else if (d_q4 <= d_bb) begin
      d_mag = d_bb - d_q4;
      d_neg = 1'b0;
    end else begin
      d_mag = d_q4 - d_bb;
      d_neg = 1'b1;
    end
  end

  logic                s2_v_q;
  logic signed [W-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic [DW-1:0]       s2_dmag_q;
  logic                s2_dneg_q;
  logic                s2_za_q, s2_zb_q, s2_zc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_c_q    <= s1_c_q;
      s2_dmag_q <= d_mag;
      s2_dneg_q <= d_neg;
      s2_za_q   <= s1_za_q;
      s2_zb_q   <= s1_zb_q;
      s2_zc_q   <= s1_zc_q;
    end
  end

  // Classify the equation; its register is the head of the square root line
  logic [SW:0]         sq_v_q;
  logic signed [W-1:0] sq_a_q [SW+1];
  logic signed [W-1:0] sq_b_q [SW+1];
  logic signed [W-1:0] sq_c_q [SW+1];
  mode_e               sq_mode_q [SW+1];
  qrs_pkg::status_e    sq_st_q [SW+1];
  logic [RADW-1:0]     sq_rad_q [SW+1];
  logic [RW-1:0]       sq_rem_q [SW+1];
  logic [SW-1:0]       sq_root_q [SW+1];

  logic             d_small;
  mode_e            cls_mode;
  qrs_pkg::status_e cls_st;

  assign d_small = CMPW'(s2_dmag_q) < (CMPW'(tol_eff) << F);

  always_comb begin
    priority if (s2_za_q && s2_zb_q && s2_zc_q) begin
      cls_mode = MODE_ZERO;
      cls_st   = qrs_pkg::ST_ANY;
    end else if (s2_za_q && s2_zb_q) begin
      cls_mode = MODE_ZERO;
      cls_st   = qrs_pkg::ST_NONE;
    end else if (s2_za_q) begin
      cls_mode = MODE_LIN;
      cls_st   = qrs_pkg::ST_ONE;
    end else if (d_small) begin
      cls_mode = MODE_DBL;
      cls_st   = qrs_pkg::ST_ONE;
    end else if (s2_dneg_q) begin
      cls_mode = MODE_ZERO;
      cls_st   = qrs_pkg::ST_NONE;
    end else begin
      cls_mode = MODE_TWO;
      cls_st   = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_a_q[0]    <= s2_a_q;
      sq_b_q[0]    <= s2_b_q;
      sq_c_q[0]    <= s2_c_q;
      sq_mode_q[0] <= cls_mode;
      sq_st_q[0]   <= cls_st;
      sq_rad_q[0]  <= RADW'(s2_dmag_q);
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
    end
  end

  // Square root: one root bit per stage, most significant first
  for (genvar j = 1; j <= SW; j++) begin : g_sqrt
    logic [RW+1:0] rem_t, trial, rem_s;
    logic          ge;

    assign rem_t = {sq_rem_q[j-1], sq_rad_q[j-1][RADW-1 -: 2]};
    assign trial = (RW+2)'({sq_root_q[j-1], 2'b01});
    assign ge    = rem_t >= trial;
    assign rem_s = ge ? (rem_t - trial) : rem_t;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j] <= 1'b0;
      end else if (adv) begin
        sq_v_q[j] <= sq_v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_a_q[j]    <= sq_a_q[j-1];
        sq_b_q[j]    <= sq_b_q[j-1];
        sq_c_q[j]    <= sq_c_q[j-1];
        sq_mode_q[j] <= sq_mode_q[j-1];
        sq_st_q[j]   <= sq_st_q[j-1];
        sq_rad_q[j]  <= sq_rad_q[j-1] << 2;
        sq_rem_q[j]  <= rem_s[RW-1:0];
        sq_root_q[j] <= {sq_root_q[j-1][SW-2:0], ge};
      end
    end
  end

  // Numerators and divisor; their register is the head of the divider line
  logic [NW:0]      dv_v_q;
  mode_e            dv_mode_q [NW+1];
  qrs_pkg::status_e dv_st_q [NW+1];
  logic             dv_negp_q [NW+1];
  logic             dv_negm_q [NW+1];
  logic [VW-1:0]    dv_den_q [NW+1];
  logic [NW-1:0]    dv_np_q [NW+1];
  logic [NW-1:0]    dv_nm_q [NW+1];
  logic [VW-1:0]    dv_rp_q [NW+1];
  logic [VW-1:0]    dv_rm_q [NW+1];
  logic [NW-1:0]    dv_qp_q [NW+1];
  logic [NW-1:0]    dv_qm_q [NW+1];

  logic signed [NBW-1:0] nu_b, nu_s, nu_p, nu_m, nu_den;
  logic [NBW-1:0]        nu_pmag, nu_mmag, nu_dmag;

  assign nu_b = -(NBW'(sq_b_q[SW]));
  assign nu_s = $signed({1'b0, sq_root_q[SW]});

  always_comb begin
    unique case (sq_mode_q[SW])
      MODE_LIN: begin
        nu_p   = -(NBW'(sq_c_q[SW]));
        nu_m   = '0;
        nu_den = NBW'(sq_b_q[SW]);
      end
      MODE_TWO: begin
        nu_p   = nu_b + nu_s;
        nu_m   = nu_b - nu_s;
        nu_den = NBW'(sq_a_q[SW]) <<< 1;
      end
      default: begin
        nu_p   = nu_b;
        nu_m   = '0;
        nu_den = NBW'(sq_a_q[SW]) <<< 1;
      end
    endcase
  end

  assign nu_pmag = nu_p[NBW-1] ? (~nu_p + NBW'(1)) : nu_p;
  assign nu_mmag = nu_m[NBW-1] ? (~nu_m + NBW'(1)) : nu_m;
  assign nu_dmag = nu_den[NBW-1] ? (~nu_den + NBW'(1)) : nu_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sq_v_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_mode_q[0] <= sq_mode_q[SW];
      dv_st_q[0]   <= sq_st_q[SW];
      dv_negp_q[0] <= nu_p[NBW-1] ^ nu_den[NBW-1];
      dv_negm_q[0] <= nu_m[NBW-1] ^ nu_den[NBW-1];
      dv_den_q[0]  <= nu_dmag[VW-1:0];
      dv_np_q[0]   <= {nu_pmag[W:0], {F{1'b0}}};
      dv_nm_q[0]   <= {nu_mmag[W:0], {F{1'b0}}};
      dv_rp_q[0]   <= '0;
      dv_rm_q[0]   <= '0;
      dv_qp_q[0]   <= '0;
      dv_qm_q[0]   <= '0;
    end
  end

  // Restoring dividers for both roots: one quotient bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [VW:0] tp, tm, dd, sp, sm;
    logic        gp, gm;

    assign dd = {1'b0, dv_den_q[k-1]};
    assign tp = {dv_rp_q[k-1], dv_np_q[k-1][NW-1]};
    assign tm = {dv_rm_q[k-1], dv_nm_q[k-1][NW-1]};
    assign gp = tp >= dd;
    assign gm = tm >= dd;
    assign sp = gp ? (tp - dd) : tp;
    assign sm = gm ? (tm - dd) : tm;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_mode_q[k] <= dv_mode_q[k-1];
        dv_st_q[k]   <= dv_st_q[k-1];
        dv_negp_q[k] <= dv_negp_q[k-1];
        dv_negm_q[k] <= dv_negm_q[k-1];
        dv_den_q[k]  <= dv_den_q[k-1];
        dv_np_q[k]   <= dv_np_q[k-1] << 1;
        dv_nm_q[k]   <= dv_nm_q[k-1] << 1;
        dv_rp_q[k]   <= sp[VW-1:0];
        dv_rm_q[k]   <= sm[VW-1:0];
        dv_qp_q[k]   <= {dv_qp_q[k-1][NW-2:0], gp};
        dv_qm_q[k]   <= {dv_qm_q[k-1][NW-2:0], gm};
      end
    end
  end

  // Apply quotient signs and drop roots that the status does not report
  logic signed [SVW-1:0] fx_qp, fx_qm, fx_vp, fx_vm;

  assign fx_qp = $signed({1'b0, dv_qp_q[NW]});
  assign fx_qm = $signed({1'b0, dv_qm_q[NW]});

  always_comb begin
    unique case (dv_mode_q[NW])
      MODE_LIN, MODE_DBL: begin
        fx_vp = dv_negp_q[NW] ? -fx_qp : fx_qp;
        fx_vm = '0;
      end
      MODE_TWO: begin
        fx_vp = dv_negp_q[NW] ? -fx_qp : fx_qp;
        fx_vm = dv_negm_q[NW] ? -fx_qm : fx_qm;
      end
      default: begin
        fx_vp = '0;
        fx_vm = '0;
      end
    endcase
  end

  logic                  sf_v_q;
  qrs_pkg::status_e      sf_st_q;
  logic signed [SVW-1:0] sf_vp_q, sf_vm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_v_q <= 1'b0;
    end else if (adv) begin
      sf_v_q <= dv_v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sf_st_q <= dv_st_q[NW];
      sf_vp_q <= fx_vp;
      sf_vm_q <= fx_vm;
    end
  end

  // Sum the unclipped roots
  logic                   ss_v_q;
  qrs_pkg::status_e       ss_st_q;
  logic signed [SUMW-1:0] ss_vp_q, ss_vm_q, ss_vs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_v_q <= 1'b0;
    end else if (adv) begin
      ss_v_q <= sf_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ss_st_q <= sf_st_q;
      ss_vp_q <= SUMW'(sf_vp_q);
      ss_vm_q <= SUMW'(sf_vm_q);
      ss_vs_q <= SUMW'(sf_vp_q) + SUMW'(sf_vm_q);
    end
  end

  // Clip each value to the word range and flag any clipping
  function automatic logic is_ovf(input logic signed [SUMW-1:0] v);
    logic [SUMW-W:0] hi;
    hi = v[SUMW-1:W-1];
    return !((&hi) || !(|hi));
  endfunction

  function automatic logic signed [W-1:0] clip_w(input logic signed [SUMW-1:0] v);
    logic signed [W-1:0] lim;
    lim = v[SUMW-1] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
    return is_ovf(v) ? lim : v[W-1:0];
  endfunction

  qrs_pkg::status_e    out_st_q;
  logic signed [W-1:0] out_rp_q, out_rm_q, out_rs_q;
  logic                out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= ss_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_st_q  <= ss_st_q;
      out_rp_q  <= clip_w(ss_vp_q);
      out_rm_q  <= clip_w(ss_vm_q);
      out_rs_q  <= clip_w(ss_vs_q);
      out_sat_q <= is_ovf(ss_vp_q) || is_ovf(ss_vm_q) || is_ovf(ss_vs_q);
    end
  end

  // Drive the result channel
  assign root_if.valid = out_v_q;

  always_comb begin
    root_if.data.root_status = out_st_q;
    root_if.data.root_plus   = qrs_pkg::FIELD_BITS'(out_rp_q);
    root_if.data.root_minus  = qrs_pkg::FIELD_BITS'(out_rm_q);
    root_if.data.root_sum    = qrs_pkg::FIELD_BITS'(out_rs_q);
    root_if.data.saturated   = out_sat_q;
  end

endmodule

FILE: src/qrs_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the quadratic root solver and its bind statement.
// Depends on qrs_pkg and on quadratic_root_solver.
module qrs_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input qrs_pkg::root_t out_data_i
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // Stall the input while the result waits
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  // Report no values when every x is a root
  a_any_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.root_status == qrs_pkg::ST_ANY |->
      out_data_i.root_plus == '0 && out_data_i.root_minus == '0 &&
      out_data_i.root_sum == '0 && !out_data_i.saturated)
    else $error("values reported for identity equation");

  // Report no first root, no sum and no clipping when there is no real root
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.root_status == qrs_pkg::ST_NONE |->
      out_data_i.root_plus == '0 && out_data_i.root_sum == '0 &&
      !out_data_i.saturated)
    else $error("values reported without real root");

  // Keep the second root clear unless two roots exist
  a_minus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.root_status != qrs_pkg::ST_TWO |->
      out_data_i.root_minus == '0)
    else $error("second root set without two roots");

endmodule

bind quadratic_root_solver qrs_chk u_qrs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (coef_if.ready),
  .out_valid_i (root_if.valid),
  .out_ready_i (root_if.ready),
  .out_data_i  (root_if.data)
);
